@@ rtl/core/lsgr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsgr_pkg
// Shared types and constants of the line step generator with speed ramp.
// ----------------------------------------------------------------------------
package lsgr_pkg;

  // Fixed field widths.
  localparam int unsigned DELTA_BITS = 21;
  localparam int unsigned DELAY_BITS = 20;
  localparam int unsigned MDIV_BITS  = 9;
  localparam int unsigned WAIT_BITS  = 21;
  localparam int unsigned CFG_BITS   = 20;

  // Parameter defaults.
  localparam int unsigned COUNT_BITS_DEF = 21;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Register reset values.
  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 20'd2500;
  localparam logic [MDIV_BITS-1:0]  MDIV_RESET  = 9'd16;

  // Command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_STEP_DELAY   = 1'b0;
  localparam logic REG_MICROSTEP_DIV = 1'b1;

  // Status of the line walk for the pending tick.
  typedef struct packed {
    logic active;
    logic step_x;
    logic step_y;
    logic dir_x;
    logic dir_y;
    logic last;
  } line_flags_t;

endpackage : lsgr_pkg
`default_nettype wire

@@ rtl/core/lsgr_cmpsub.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsgr_cmpsub
// Shared compare and subtract unit: one restoring division step.
// ----------------------------------------------------------------------------
module lsgr_cmpsub #(
  parameter int unsigned W = 27
) (
  input  wire logic [W-1:0] cand_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              ge_o,
  output logic [W-1:0]      diff_o
);

  logic [W:0] sub_w;

  // The borrow out of the subtraction tells whether the candidate reaches the divisor.
  assign sub_w  = {1'b0, cand_i} - {1'b0, divisor_i};
  assign ge_o   = ~sub_w[W];
  assign diff_o = sub_w[W-1:0];

endmodule : lsgr_cmpsub
`default_nettype wire

@@ rtl/core/lsgr_line.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsgr_line
// Bresenham line state: loads the distances and advances one step per tick.
// ----------------------------------------------------------------------------
module lsgr_line
  import lsgr_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire logic signed [DELTA_BITS-1:0] delta_x_i,
  input  wire logic signed [DELTA_BITS-1:0] delta_y_i,
  input  wire logic                         adv_i,
  output line_flags_t                       flags_o,
  output logic [COUNT_BITS-1:0]             index_o,
  output logic [COUNT_BITS-1:0]             major_o
);

  localparam logic [32:0] CntMax = (33'd1 << COUNT_BITS) - 33'd1;

  logic                  active_q, xmaj_q, dirx_q, diry_q;
  logic [COUNT_BITS-1:0] idx_q, major_q, minor_q;
  logic [COUNT_BITS:0]   err_q;

  logic [DELTA_BITS-1:0] magx_w, magy_w;
  logic [32:0]           magx_l, magy_l;
  logic [COUNT_BITS-1:0] satx_w, saty_w, maj_w, min_w;
  logic                  xmaj_w;
  logic [COUNT_BITS:0]   err_sum_w, err_next_w, idx_inc_w;
  logic                  minor_step_w, last_w;

  // The magnitude of the most negative distance still fits the unsigned width.
  assign magx_w = delta_x_i[DELTA_BITS-1] ? DELTA_BITS'(-delta_x_i) : delta_x_i;
  assign magy_w = delta_y_i[DELTA_BITS-1] ? DELTA_BITS'(-delta_y_i) : delta_y_i;
  assign magx_l = 33'(magx_w);
  assign magy_l = 33'(magy_w);
  assign satx_w = (magx_l > CntMax) ? CntMax[COUNT_BITS-1:0] : magx_l[COUNT_BITS-1:0];
  assign saty_w = (magy_l > CntMax) ? CntMax[COUNT_BITS-1:0] : magy_l[COUNT_BITS-1:0];
  assign xmaj_w = satx_w > saty_w;
  assign maj_w  = xmaj_w ? satx_w : saty_w;
  assign min_w  = xmaj_w ? saty_w : satx_w;

  assign err_sum_w    = err_q + {1'b0, minor_q};
  assign minor_step_w = err_sum_w >= {1'b0, major_q};
  assign err_next_w   = minor_step_w ? (err_sum_w - {1'b0, major_q}) : err_sum_w;
  assign idx_inc_w    = {1'b0, idx_q} + {{COUNT_BITS{1'b0}}, 1'b1};
  assign last_w       = idx_inc_w >= {1'b0, major_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      xmaj_q   <= 1'b0;
      dirx_q   <= 1'b0;
      diry_q   <= 1'b0;
      idx_q    <= '0;
      major_q  <= '0;
      minor_q  <= '0;
      err_q    <= '0;
    end else if (load_i) begin
      active_q <= maj_w != '0;
      xmaj_q   <= xmaj_w;
      dirx_q   <= ~delta_x_i[DELTA_BITS-1] && (delta_x_i != '0);
      diry_q   <= delta_y_i[DELTA_BITS-1] || (delta_y_i == '0);
      idx_q    <= '0;
      major_q  <= maj_w;
      minor_q  <= min_w;
      err_q    <= {2'b00, maj_w[COUNT_BITS-1:1]};
    end else if (adv_i) begin
      err_q <= err_next_w;
      idx_q <= idx_inc_w[COUNT_BITS-1:0];
      if (last_w) begin
        active_q <= 1'b0;
      end
    end
  end

  always_comb begin
    flags_o.active = active_q;
    flags_o.step_x = xmaj_q | minor_step_w;
    flags_o.step_y = ~xmaj_q | minor_step_w;
    flags_o.dir_x  = dirx_q;
    flags_o.dir_y  = diry_q;
    flags_o.last   = last_w;
  end

  assign index_o = idx_q;
  assign major_o = major_q;

endmodule : lsgr_line
`default_nettype wire

@@ rtl/core/line_step_generator_with_ramp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// line_step_generator_with_ramp
// Bresenham line stepper that reports a ramp scaled wait time for each step.
// ----------------------------------------------------------------------------
// A tick item passes through setup, the ramp division, the multiply, the load and the
// wait division before its result is registered; in the middle part of a line, where no
// ramp division is needed, it skips the ramp division. A start item loads the line state.
// One item is worked at a time, so the next item is taken in the cycle after the result
// is registered; the pace is set by the shared compare and subtract unit.
// Reset clears the line state and the handshakes and loads the register defaults.
module line_step_generator_with_ramp
  import lsgr_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic                         cfg_index_i,
  input  wire logic [CFG_BITS-1:0]          cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         command_i,
  input  wire logic signed [DELTA_BITS-1:0] delta_x_i,
  input  wire logic signed [DELTA_BITS-1:0] delta_y_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              step_x_o,
  output logic                              dir_x_o,
  output logic                              step_y_o,
  output logic                              dir_y_o,
  output logic [WAIT_BITS-1:0]              wait_us_o,
  output logic                              last_o
);

  localparam int unsigned W      = COUNT_BITS + 6;
  localparam int unsigned FW     = FRAC_BITS + 1;
  localparam int unsigned ProdW  = DELAY_BITS + FW;
  localparam int unsigned MaxSt  = (WAIT_BITS > FW) ? WAIT_BITS : FW;
  localparam int unsigned CntW   = $clog2(MaxSt);
  localparam logic [FW-1:0] FactOne   = FW'(1) << FRAC_BITS;
  localparam logic [FW-1:0] FactFloor = FW'((1 << FRAC_BITS) / 10);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_RDIV  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;
  localparam logic [2:0] ST_WDIV  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [DELAY_BITS-1:0] delay_q;
  logic [MDIV_BITS-1:0]  mdiv_q;
  logic [W-1:0]          rem_q, rem_d, dsr_q, dsr_d;
  logic [FW-1:0]         fact_q, fact_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [ProdW-1:0]      prod_q, prod_d;
  logic [WAIT_BITS-1:0]  dvd_q, dvd_d;
  logic                  out_valid_q;
  line_flags_t           res_q;
  logic [WAIT_BITS-1:0]  wait_q;

  line_flags_t           flags_w;
  logic [COUNT_BITS-1:0] index_w, major_w;
  logic                  in_acc_w, load_w, adv_w, slot_free_w;
  logic [W-1:0]          cand_w, diff_w;
  logic                  ge_w;
  logic [W-1:0]          i_w, n_w, i10_w, n9_w, n7_w, n25_w, i48_w, n20_w, n2_w;
  logic                  ramp_up_w, ramp_down_w;
  logic [FW-1:0]         fact_eff_w;
  logic [MDIV_BITS-1:0]  mdiv_eff_w;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = state_q == ST_IDLE;
  assign in_acc_w    = in_valid_i && in_ready_o;
  assign load_w      = in_acc_w && (command_i == CMD_START);
  assign slot_free_w = ~out_valid_q | out_ready_i;
  assign adv_w       = (state_q == ST_DONE) && slot_free_w;

  lsgr_line #(
    .COUNT_BITS (COUNT_BITS)
  ) u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load_w),
    .delta_x_i (delta_x_i),
    .delta_y_i (delta_y_i),
    .adv_i     (adv_w),
    .flags_o   (flags_w),
    .index_o   (index_w),
    .major_o   (major_w)
  );

  lsgr_cmpsub #(
    .W (W)
  ) u_cmpsub (
    .cand_i    (cand_w),
    .divisor_i (dsr_q),
    .ge_o      (ge_w),
    .diff_o    (diff_w)
  );

  // Ramp regions: 10i < n ramps down from 1.25, 10i > 9n ramps up from 1.
  assign i_w         = W'(index_w);
  assign n_w         = W'(major_w);
  assign i10_w       = i_w * W'(10);
  assign n9_w        = n_w * W'(9);
  assign n7_w        = n_w * W'(7);
  assign n25_w       = n_w * W'(25);
  assign i48_w       = i_w * W'(48);
  assign n20_w       = n_w * W'(20);
  assign n2_w        = n_w << 1;
  assign ramp_up_w   = i10_w < n_w;
  assign ramp_down_w = i10_w > n9_w;

  assign fact_eff_w = (fact_q == '0) ? FactFloor : fact_q;
  assign mdiv_eff_w = (mdiv_q == '0) ? MDIV_BITS'(1) : mdiv_q;

  // The first ramp step compares the numerator itself, whose quotient is below two.
  always_comb begin
    cand_w = {rem_q[W-2:0], 1'b0};
    if (state_q == ST_WDIV) begin
      cand_w = {rem_q[W-2:0], dvd_q[WAIT_BITS-1]};
    end else if (cnt_q == '0) begin
      cand_w = rem_q;
    end
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    fact_d  = fact_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    dvd_d   = dvd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc_w && (command_i == CMD_TICK) && flags_w.active) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cnt_d = '0;
        if (n_w == '0 || (!ramp_up_w && !ramp_down_w)) begin
          fact_d  = FactOne;
          state_d = ST_MUL;
        end else if (ramp_up_w) begin
          rem_d   = n25_w - i48_w;
          dsr_d   = n20_w;
          state_d = ST_RDIV;
        end else begin
          rem_d   = i10_w - n7_w;
          dsr_d   = n2_w;
          state_d = ST_RDIV;
        end
      end
      ST_RDIV: begin
        rem_d  = ge_w ? diff_w : cand_w;
        fact_d = {fact_q[FW-2:0], ge_w};
        cnt_d  = cnt_q + CntW'(1);
        if (cnt_q == CntW'(FRAC_BITS)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = ProdW'(delay_q) * ProdW'(fact_eff_w);
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // Dividing by the divisor times 2^FRAC_BITS equals dropping the
        // fraction first; the quotient always fits the wait width.
        dvd_d   = prod_q[FRAC_BITS +: WAIT_BITS];
        rem_d   = '0;
        dsr_d   = W'(mdiv_eff_w);
        cnt_d   = '0;
        state_d = ST_WDIV;
      end
      ST_WDIV: begin
        rem_d = ge_w ? diff_w : cand_w;
        dvd_d = {dvd_q[WAIT_BITS-2:0], ge_w};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(WAIT_BITS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free_w) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      delay_q <= DELAY_RESET;
      mdiv_q  <= MDIV_RESET;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_STEP_DELAY:    delay_q <= cfg_data_i[DELAY_BITS-1:0];
          REG_MICROSTEP_DIV: mdiv_q  <= cfg_data_i[MDIV_BITS-1:0];
          default:           delay_q <= delay_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    fact_q <= fact_d;
    prod_q <= prod_d;
    dvd_q  <= dvd_d;
  end

  // Output register: the next item can be taken while a result waits here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_w) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      res_q  <= flags_w;
      wait_q <= dvd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign step_x_o    = res_q.step_x;
  assign dir_x_o     = res_q.dir_x;
  assign step_y_o    = res_q.step_y;
  assign dir_y_o     = res_q.dir_y;
  assign wait_us_o   = wait_q;
  assign last_o      = res_q.last;

endmodule : line_step_generator_with_ramp
`default_nettype wire
